// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Expression that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`endif

// ===== rtl/core/cbc_pkg.sv =====
`default_nettype none
package cbc_pkg;
  localparam int unsigned DefCapacity = 16;
  localparam int unsigned TagW = 32;
  localparam int unsigned HandleW = 16;
  localparam int unsigned ActionW = 3;

  typedef enum logic [ActionW-1:0] {
    ACT_INSERT = 3'd0,
    ACT_GET    = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_FLUSH1 = 3'd3,
    ACT_FLUSHA = 3'd4,
    ACT_DIRTY  = 3'd5
  } action_t;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [TagW-1:0]    block_tag;
    logic [HandleW-1:0] buffer_handle;
    logic               make_dirty;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic [HandleW-1:0] handle_out;
    logic               leaving_valid;
    logic [TagW-1:0]    leaving_tag;
    logic [HandleW-1:0] leaving_handle;
    logic               needs_writeback;
    logic               last;
  } rsp_t;
endpackage
`default_nettype wire

// ===== rtl/core/cbc_if.sv =====
`default_nettype none
interface cbc_req_if;
  import cbc_pkg::*;
  logic valid;
  logic ready;
  logic [ActionW-1:0] action;
  logic [TagW-1:0]    block_tag;
  logic [HandleW-1:0] buffer_handle;
  logic               make_dirty;
  modport source (output valid, action, block_tag, buffer_handle, make_dirty, input ready);
  modport sink (input valid, action, block_tag, buffer_handle, make_dirty, output ready);
endinterface

interface cbc_rsp_if;
  import cbc_pkg::*;
  logic valid;
  logic ready;
  logic               hit;
  logic [HandleW-1:0] handle_out;
  logic               leaving_valid;
  logic [TagW-1:0]    leaving_tag;
  logic [HandleW-1:0] leaving_handle;
  logic               needs_writeback;
  logic               last;
  modport source (output valid, hit, handle_out, leaving_valid, leaving_tag, leaving_handle,
                  needs_writeback, last, input ready);
  modport sink (input valid, hit, handle_out, leaving_valid, leaving_tag, leaving_handle,
                needs_writeback, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cbc_mem.sv =====
`default_nettype none
// Slot payload store: tag and handle, one write port, one registered read port.
module cbc_mem #(
  parameter int unsigned Capacity = cbc_pkg::DefCapacity,
  localparam int unsigned SlotW = $clog2(Capacity)
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [SlotW-1:0]               waddr,
  input  wire logic [cbc_pkg::TagW-1:0]       wtag,
  input  wire logic [cbc_pkg::HandleW-1:0]    whandle,
  input  wire logic [SlotW-1:0]               raddr,
  output logic      [cbc_pkg::TagW-1:0]       rtag,
  output logic      [cbc_pkg::HandleW-1:0]    rhandle
);
  import cbc_pkg::*;
  logic [TagW+HandleW-1:0] mem [Capacity];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wtag, whandle};
    end
    {rtag, rhandle} <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/core/cbc_ctrl.sv =====
`default_nettype none
// Command sequencer: tag match over a mirror of the tags, clock sweep, flush walk.
module cbc_ctrl #(
  parameter int unsigned Capacity = cbc_pkg::DefCapacity,
  localparam int unsigned SlotW = $clog2(Capacity),
  localparam int unsigned CntW = $clog2(Capacity + 1)
) (
  input  wire logic       clk,
  input  wire logic       rst,
  cbc_req_if.sink         req,
  cbc_rsp_if.source       rsp,
  output logic            busy
);
  import cbc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MATCH, S_SWEEP, S_READ, S_WALK, S_WREAD, S_OUT} state_t;

  state_t state;
  req_t   cur;
  logic [Capacity-1:0] valid_q, ref_q, dirty_q;
  logic [TagW-1:0] tag_q [Capacity];
  logic [SlotW-1:0] hand, slot, walk;
  logic [SlotW-1:0] fstack [Capacity];
  logic [CntW-1:0] fcount;
  logic            lv_pend, fl_last;
  rsp_t            out;

  logic            mem_we;
  logic [SlotW-1:0] mem_ra;
  logic [TagW-1:0] rtag;
  logic [HandleW-1:0] rhandle;

  cbc_mem #(.Capacity(Capacity)) u_mem (
    .clk(clk), .we(mem_we), .waddr(slot), .wtag(cur.block_tag),
    .whandle(cur.buffer_handle), .raddr(mem_ra), .rtag(rtag), .rhandle(rhandle)
  );

  // Priority match against the registered tag mirror.
  logic            m_any;
  logic [SlotW-1:0] m_idx;
  always_comb begin
    m_any = 1'b0;
    m_idx = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (valid_q[i] && tag_q[i] == cur.block_tag) begin
        m_any = 1'b1;
        m_idx = SlotW'(i);
      end
    end
  end

  // Next dirty slot at or after the walk pointer.
  logic            d_any;
  logic [SlotW-1:0] d_idx;
  always_comb begin
    d_any = 1'b0;
    d_idx = '0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (SlotW'(i) >= walk && valid_q[i] && dirty_q[i]) begin
        d_any = 1'b1;
        d_idx = SlotW'(i);
      end
    end
  end

  function automatic logic [SlotW-1:0] wrap_inc(input logic [SlotW-1:0] v);
    wrap_inc = (v == SlotW'(Capacity - 1)) ? '0 : v + 1'b1;
  endfunction

  // The matched slot is read during the match cycle so its handle is ready next cycle.
  always_comb begin
    mem_ra = m_idx;
    if (state == S_SWEEP || state == S_READ) mem_ra = hand;
    if (state == S_WALK || state == S_WREAD) mem_ra = d_idx;
    mem_we = (state == S_READ);
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);
  assign busy      = (state != S_IDLE);
  assign rsp.hit = out.hit;
  assign rsp.handle_out = out.handle_out;
  assign rsp.leaving_valid = out.leaving_valid;
  assign rsp.leaving_tag = out.leaving_tag;
  assign rsp.leaving_handle = out.leaving_handle;
  assign rsp.needs_writeback = out.needs_writeback;
  assign rsp.last = out.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      valid_q <= '0;
      ref_q   <= '0;
      dirty_q <= '0;
      hand    <= '0;
      fcount  <= CntW'(Capacity);
      for (int i = 0; i < Capacity; i++) fstack[i] <= SlotW'(i);
      lv_pend <= 1'b0;
      fl_last <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cur <= '{req.action, req.block_tag, req.buffer_handle, req.make_dirty};
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          // Flush all and the unused codes never report a hit.
          out <= '{hit: m_any && (cur.action inside {ACT_INSERT, ACT_GET, ACT_REMOVE,
                                                     ACT_FLUSH1, ACT_DIRTY}),
                   last: 1'b1, default: '0};
          case (cur.action)
            ACT_INSERT: begin
              if (m_any) begin
                ref_q[m_idx] <= 1'b1;
                if (cur.make_dirty) dirty_q[m_idx] <= 1'b1;
                state <= S_OUT;
              end else if (fcount != '0) begin
                slot <= fstack[fcount[SlotW-1:0] - 1'b1];
                fcount <= fcount - 1'b1;
                lv_pend <= 1'b0;
                state <= S_READ;
              end else begin
                state <= S_SWEEP;
              end
            end
            ACT_GET: begin
              if (m_any) begin
                ref_q[m_idx] <= 1'b1;
                if (cur.make_dirty) dirty_q[m_idx] <= 1'b1;
                state <= S_WREAD;
                fl_last <= 1'b0;
              end else begin
                state <= S_OUT;
              end
            end
            ACT_REMOVE: begin
              if (m_any) begin
                valid_q[m_idx] <= 1'b0;
                ref_q[m_idx] <= 1'b0;
                dirty_q[m_idx] <= 1'b0;
                if (fcount < CntW'(Capacity)) begin
                  fstack[fcount[SlotW-1:0]] <= m_idx;
                  fcount <= fcount + 1'b1;
                end
              end
              state <= S_OUT;
            end
            ACT_FLUSH1: begin
              if (m_any && dirty_q[m_idx]) begin
                dirty_q[m_idx] <= 1'b0;
                state <= S_WREAD;
                fl_last <= 1'b1;
              end else begin
                state <= S_OUT;
              end
            end
            ACT_FLUSHA: begin
              walk <= '0;
              state <= S_WALK;
            end
            ACT_DIRTY: begin
              if (m_any) dirty_q[m_idx] <= 1'b1;
              state <= S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_SWEEP: begin
          // One slot per cycle; a referenced slot gets its second chance.
          if (ref_q[hand]) begin
            ref_q[hand] <= 1'b0;
            hand <= wrap_inc(hand);
          end else begin
            slot <= hand;
            lv_pend <= 1'b1;
            hand <= wrap_inc(hand);
            state <= S_READ;
          end
        end
        S_READ: begin
          // Old contents were read last cycle from the victim slot.
          out.leaving_valid <= lv_pend;
          out.leaving_tag <= lv_pend ? rtag : '0;
          out.leaving_handle <= lv_pend ? rhandle : '0;
          out.needs_writeback <= lv_pend & dirty_q[slot];
          valid_q[slot] <= 1'b1;
          ref_q[slot] <= 1'b1;
          dirty_q[slot] <= cur.make_dirty;
          tag_q[slot] <= cur.block_tag;
          state <= S_OUT;
        end
        S_WREAD: begin
          if (cur.action == ACT_GET) begin
            out.handle_out <= rhandle;
          end else begin
            out.leaving_valid <= 1'b1;
            out.leaving_tag <= rtag;
            out.leaving_handle <= rhandle;
            out.needs_writeback <= 1'b1;
          end
          out.last <= (cur.action != ACT_FLUSHA);
          state <= S_OUT;
        end
        S_WALK: begin
          if (d_any) begin
            out <= '0;
            dirty_q[d_idx] <= 1'b0;
            walk <= d_idx;
            fl_last <= (d_idx == SlotW'(Capacity - 1));
            state <= S_WREAD;
          end else begin
            out <= '{last: 1'b1, default: '0};
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (rsp.ready) begin
            if (cur.action == ACT_FLUSHA && !out.last) begin
              if (fl_last) begin
                out <= '{last: 1'b1, default: '0};
                fl_last <= 1'b0;
              end else begin
                walk <= wrap_inc(walk);
                state <= S_WALK;
              end
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/clock_block_cache.sv =====
// A command passes the match state, and a read state for a get hit, a dirty single flush
// or a new insert, before its result; a full-cache insert first sweeps the clock hand over up
// to capacity plus one slots. Flush all: one result per dirty slot, then a closing result.
// One command is in flight at a time; the next can be taken in the cycle after its last result.
// Synchronous active-high reset empties the cache and refills the free stack at once.
`default_nettype none
`include "assert_macros.svh"
module clock_block_cache #(
  parameter int unsigned Capacity = cbc_pkg::DefCapacity
) (
  input wire logic  clk,
  input wire logic  rst,
  cbc_req_if.sink   req,
  cbc_rsp_if.source rsp
);
  import cbc_pkg::*;
  logic busy;

  cbc_ctrl #(.Capacity(Capacity)) u_ctrl (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp), .busy(busy)
  );

  `ASSERT_IMPL(a_no_accept_busy, clk, rst, busy, !req.ready, "input taken while busy")
  `ASSERT_IMPL(a_idle_no_out, clk, rst, !busy, !rsp.valid, "result while idle")
  `ASSERT_IMPL(a_single_hdr, clk, rst, rsp.valid && rsp.hit && !rsp.last, 1'b0,
               "flush walk result flagged as hit")
endmodule
`default_nettype wire

// ===== tb/cbc_tb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module cbc_tb_checker #(
  parameter int unsigned Capacity = 16
) (
  input wire logic clk,
  input wire logic rst,
  cbc_req_if.sink  req,
  cbc_rsp_if.sink  rsp,
  output int       fail_count,
  output int       pending_count
);
  import cbc_pkg::*;

  typedef struct packed {
    logic               hit;
    logic [HandleW-1:0] handle_out;
    logic               leaving_valid;
    logic [TagW-1:0]    leaving_tag;
    logic [HandleW-1:0] leaving_handle;
    logic               needs_writeback;
    logic               last;
  } answer_t;

  logic [TagW-1:0]    tags [Capacity];
  logic [HandleW-1:0] handles [Capacity];
  logic               used [Capacity];
  logic               refd [Capacity];
  logic               dirty [Capacity];
  int unsigned        hand;
  int unsigned        free_stack [Capacity];
  int unsigned        free_top;
  answer_t            expected_answers [$];

  initial begin
    for (int i = 0; i < Capacity; i++) begin
      used[i] = 0;
      refd[i] = 0;
      dirty[i] = 0;
      free_stack[i] = i;
    end
    free_top = Capacity;
    hand = 0;
    fail_count = 0;
  end

  assign pending_count = expected_answers.size();

  function automatic answer_t blank(logic hit_bit, logic last_bit);
    answer_t a;
    a = '0;
    a.hit = hit_bit;
    a.last = last_bit;
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  task automatic predict_cache(logic [ActionW-1:0] act, logic [TagW-1:0] tag,
                               logic [HandleW-1:0] bh, logic mk);
    int s;
    int unsigned v;
    answer_t a;
    s = -1;
    for (int i = Capacity - 1; i >= 0; i--)
      if (used[i] && tags[i] == tag) s = i;
    a = blank(s >= 0, 1'b1);
    case (act)
      ACT_INSERT: begin
        if (s >= 0) begin
          refd[s] = 1;
          if (mk) dirty[s] = 1;
        end else begin
          if (free_top > 0) begin
            free_top--;
            v = free_stack[free_top];
          end else begin
            v = hand;
            while (refd[v]) begin
              refd[v] = 0;
              v = (v + 1) % Capacity;
            end
            hand = (v + 1) % Capacity;
            a.leaving_valid = 1;
            a.leaving_tag = tags[v];
            a.leaving_handle = handles[v];
            a.needs_writeback = dirty[v];
          end
          tags[v] = tag;
          handles[v] = bh;
          used[v] = 1;
          refd[v] = 1;
          dirty[v] = mk;
        end
      end
      ACT_GET: begin
        if (s >= 0) begin
          refd[s] = 1;
          if (mk) dirty[s] = 1;
          a.handle_out = handles[s];
        end
      end
      ACT_REMOVE: begin
        if (s >= 0) begin
          used[s] = 0;
          refd[s] = 0;
          dirty[s] = 0;
          if (free_top < Capacity) begin
            free_stack[free_top] = s;
            free_top++;
          end
        end
      end
      ACT_FLUSH1: begin
        if (s >= 0 && dirty[s]) begin
          dirty[s] = 0;
          a.leaving_valid = 1;
          a.leaving_tag = tags[s];
          a.leaving_handle = handles[s];
          a.needs_writeback = 1;
        end
      end
      ACT_FLUSHA: begin
        for (int i = 0; i < Capacity; i++) begin
          if (used[i] && dirty[i]) begin
            answer_t w;
            w = blank(1'b0, 1'b0);
            dirty[i] = 0;
            w.leaving_valid = 1;
            w.leaving_tag = tags[i];
            w.leaving_handle = handles[i];
            w.needs_writeback = 1;
            expected_answers.insert(expected_answers.size(), w);
          end
        end
        a = blank(1'b0, 1'b1);
      end
      ACT_DIRTY: begin
        if (s >= 0) dirty[s] = 1;
      end
      default: a = blank(1'b0, 1'b1);
    endcase
    expected_answers.insert(expected_answers.size(), a);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready)
        predict_cache(req.action, req.block_tag, req.buffer_handle, req.make_dirty);
      if (rsp.valid && rsp.ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          answer_t w;
          w = expected_answers.pop_front();
          if (rsp.hit !== w.hit) report_mismatch("hit", rsp.hit, w.hit);
          if (rsp.handle_out !== w.handle_out)
            report_mismatch("handle_out", rsp.handle_out, w.handle_out);
          if (rsp.leaving_valid !== w.leaving_valid)
            report_mismatch("leaving_valid", rsp.leaving_valid, w.leaving_valid);
          if (rsp.leaving_tag !== w.leaving_tag)
            report_mismatch("leaving_tag", rsp.leaving_tag, w.leaving_tag);
          if (rsp.leaving_handle !== w.leaving_handle)
            report_mismatch("leaving_handle", rsp.leaving_handle, w.leaving_handle);
          if (rsp.needs_writeback !== w.needs_writeback)
            report_mismatch("needs_writeback", rsp.needs_writeback, w.needs_writeback);
          if (rsp.last !== w.last) report_mismatch("last", rsp.last, w.last);
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_clock_block_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_clock_block_cache;
  import cbc_pkg::*;

  localparam int unsigned NumRandom = 460;
  localparam int unsigned IdleLimit = 5000;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_off;
  int   idle_cycles;
  logic [TagW-1:0] tag_pool [8];

  cbc_req_if req ();
  cbc_rsp_if rsp ();

  clock_block_cache u_top (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  cbc_tb_checker #(.Capacity(DefCapacity)) u_checker (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial clk = 0;
  always #5 clk = ~clk;

  // Valid stays up after a transaction and drops only when the sender idles.
  task automatic send_command(logic [ActionW-1:0] act, logic [TagW-1:0] tag,
                              logic [HandleW-1:0] bh, logic mk);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req.valid <= 0;
      @(negedge clk);
    end
    req.valid <= 1;
    req.action <= act;
    req.block_tag <= tag;
    req.buffer_handle <= bh;
    req.make_dirty <= mk;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Tags come mostly from a small pool so that hits, evictions and removals recur.
  function automatic logic [TagW-1:0] pick_tag();
    if ($urandom_range(9) < 8) return tag_pool[$urandom_range(7)] + $urandom_range(23);
    return $urandom;
  endfunction

  always @(negedge clk) begin
    if (rst || hold_off) rsp.ready <= 0;
    else rsp.ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (!rst);
    forever begin
      @(posedge clk);
      if (idle_cycles >= IdleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // A long receiver hold-off while commands keep coming, so the input stalls.
  initial begin
    hold_off = 0;
    wait (!rst);
    repeat (300) @(posedge clk);
    @(negedge clk);
    hold_off = 1;
    repeat (200) @(negedge clk);
    hold_off = 0;
  end

  initial begin
    logic [ActionW-1:0] act;
    rst = 1;
    idle_cycles = 0;
    send_idle_pct = 37;
    recv_idle_pct = 67;
    req.valid = 0;
    req.action = ACT_INSERT;
    req.block_tag = '0;
    req.buffer_handle = '0;
    req.make_dirty = 0;
    rsp.ready = 0;
    for (int i = 0; i < 8; i++) tag_pool[i] = $urandom;
    repeat (3) @(negedge clk);
    rst = 0;

    send_command(ACT_INSERT, 32'h0, 16'h0, 0);
    send_command(ACT_INSERT, 32'hFFFF_FFFF, 16'hFFFF, 1);
    send_command(ACT_INSERT, 32'hFFFF_FFFF, 16'h1234, 0);
    send_command(ACT_GET, 32'hFFFF_FFFF, 16'h0, 0);
    send_command(ACT_GET, 32'h0, 16'h0, 1);
    send_command(ACT_GET, 32'h5555_AAAA, 16'h0, 0);
    send_command(ACT_DIRTY, 32'h0, 16'h0, 0);
    send_command(ACT_DIRTY, 32'h1, 16'h0, 0);
    send_command(ACT_FLUSH1, 32'h0, 16'h0, 0);
    send_command(ACT_FLUSH1, 32'h0, 16'h0, 0);
    send_command(ACT_FLUSH1, 32'h77, 16'h0, 0);
    send_command(ACT_FLUSHA, 32'h0, 16'h0, 0);
    // Fill past capacity to force evictions, dirty ones included.
    for (int i = 0; i < 18; i++)
      send_command(ACT_INSERT, 32'(32'h100 + i), 16'(16'hA000 + i), i[0]);
    send_command(ACT_REMOVE, 32'h105, 16'h0, 0);
    send_command(ACT_REMOVE, 32'h105, 16'h0, 0);
    send_command(3'd6, 32'h0, 16'h0, 0);
    send_command(3'd7, 32'hFFFF_FFFF, 16'hFFFF, 1);
    send_command(ACT_FLUSHA, 32'h0, 16'h0, 0);

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) begin
        send_idle_pct = 67;
        recv_idle_pct = 37;
      end else if (n == 2 * NumRandom / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5, 6: act = ACT_INSERT;
        7, 8, 9, 10: act = ACT_GET;
        11, 12, 13: act = ACT_REMOVE;
        14, 15: act = ACT_FLUSH1;
        16: act = ACT_FLUSHA;
        17, 18: act = ACT_DIRTY;
        default: act = 3'($urandom_range(7, 6));
      endcase
      send_command(act, pick_tag(), 16'($urandom), 1'($urandom));
    end
    req.valid <= 0;

    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
